[src/bwst_pkg.sv]
`timescale 1ns / 1ps

package bwst_pkg;

  // one bus access as it arrives on the request channel
  typedef struct packed {
    logic        op;
    logic [1:0]  size;
    logic [31:0] addr;
    logic [31:0] wdata;
  } bwst_req_t;

  // timing result for one access
  typedef struct packed {
    logic [4:0]  cycles;
    logic        sequential;
    logic        reg_hit;
    logic [31:0] rdata;
  } bwst_rsp_t;

  // wait-control register and its decoded waits
  // rom entries: window0 n, window0 s, window1 n, window1 s, window2 n, window2 s
  typedef struct packed {
    logic [15:0]     raw;
    logic [3:0]      sram;
    logic [5:0][3:0] rom;
  } bwst_wait_t;

endpackage

[src/bwst_if.sv]
`timescale 1ns / 1ps

// access request channel
interface bwst_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [1:0]  size;
  logic [31:0] addr;
  logic [31:0] wdata;

  modport source (output valid, output op, output size, output addr, output wdata,
                  input ready);
  modport sink   (input valid, input op, input size, input addr, input wdata,
                  output ready);
endinterface

// timing result channel
interface bwst_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cycles;
  logic        sequential;
  logic        reg_hit;
  logic [31:0] rdata;

  modport source (output valid, output cycles, output sequential, output reg_hit,
                  output rdata, input ready);
  modport sink   (input valid, input cycles, input sequential, input reg_hit,
                  input rdata, output ready);
endinterface

[src/bus_wait_state_timer_top.sv]
`timescale 1ns / 1ps

// Bus wait-state timer. Each request is one bus access (read or write; byte, halfword or
// word; address and write data) and yields one result: the clock cycles charged, whether
// the access was sequential, and the wait-control register lane on a read hit. Writes to
// the wait-control lanes reprogram the decoded waits, which start at zero after reset.
// One request is accepted every cycle unless a held result stalls the input register; a
// result is taken from the input register through the combinational timing logic into
// the result register. Results may wait on the output while the next request is taken.
module bus_wait_state_timer_top (
  input  logic       clk,
  input  logic       rst_n,
  bwst_in_if.sink    in_ch,
  bwst_out_if.source out_ch
);
  import bwst_pkg::*;

  logic        in_valid_r;
  bwst_req_t   in_req_r;
  logic        out_valid_r;
  bwst_rsp_t   out_rsp_r;
  logic [31:0] seq_addr_r;
  bwst_wait_t  wait_r;

  bwst_rsp_t   rsp;
  logic [31:0] seq_addr_nxt;
  bwst_wait_t  wait_nxt;
  logic        advance;
  logic        in_ready;
  bwst_req_t   in_req;

  // the held request moves on when the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !in_valid_r || advance;

  assign in_ch.ready = in_ready;
  assign in_req      = '{op: in_ch.op, size: in_ch.size, addr: in_ch.addr,
                         wdata: in_ch.wdata};

  // timing decision and register update
  bwst_timing u_timing (
    .req          (in_req_r),
    .seq_addr     (seq_addr_r),
    .wait_cur     (wait_r),
    .rsp          (rsp),
    .seq_addr_nxt (seq_addr_nxt),
    .wait_nxt     (wait_nxt)
  );

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seq_addr_r  <= 32'd0;
      wait_r      <= '0;
    end else begin
      if (in_ready) in_valid_r <= in_ch.valid;
      if (advance) begin
        out_valid_r <= 1'b1;
        seq_addr_r  <= seq_addr_nxt;
        wait_r      <= wait_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) in_req_r <= in_req;
    if (advance) out_rsp_r <= rsp;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cycles     = out_rsp_r.cycles;
  assign out_ch.sequential = out_rsp_r.sequential;
  assign out_ch.reg_hit    = out_rsp_r.reg_hit;
  assign out_ch.rdata      = out_rsp_r.rdata;

endmodule

[src/bwst_timing.sv]
`timescale 1ns / 1ps

module bwst_timing (
  input  bwst_pkg::bwst_req_t  req,
  input  logic [31:0]          seq_addr,
  input  bwst_pkg::bwst_wait_t wait_cur,
  output bwst_pkg::bwst_rsp_t  rsp,
  output logic [31:0]          seq_addr_nxt,
  output bwst_pkg::bwst_wait_t wait_nxt
);
  import bwst_pkg::*;

  // access width codes
  localparam logic [1:0]  SIZE_BYTE = 2'd0;
  localparam logic [1:0]  SIZE_HALF = 2'd1;
  localparam logic        OP_WRITE  = 1'b1;

  // memory regions, from address bits 27..24
  localparam logic [3:0]  REG_EWRAM  = 4'h2;
  localparam logic [3:0]  REG_IO     = 4'h4;
  localparam logic [3:0]  REG_PAL    = 4'h5;
  localparam logic [3:0]  REG_VRAM   = 4'h6;
  localparam logic [3:0]  REG_ROM_LO = 4'h8;
  localparam logic [3:0]  REG_ROM_HI = 4'hD;
  localparam logic [3:0]  REG_SRAM   = 4'hE;

  localparam logic [31:0] WAIT_CTRL_ADDR = 32'h0400_0204;
  localparam logic [31:0] WAIT_CTRL_B1   = WAIT_CTRL_ADDR + 32'd1;
  localparam logic [31:0] WAIT_CTRL_WLO  = WAIT_CTRL_ADDR - 32'd2;
  localparam logic [31:0] SRAM_LIMIT     = 32'h0E00_FFFF;
  localparam logic [1:0]  WIN_LAST       = 2'd2;

  // first-access wait table
  function automatic logic [3:0] first_wait(input logic [1:0] code);
    logic [3:0] w;
    case (code)
      2'd0:    w = 4'd5;
      2'd1:    w = 4'd4;
      2'd2:    w = 4'd3;
      default: w = 4'd9;
    endcase
    return w;
  endfunction

  // second-access wait table, one pair per window
  function automatic logic [3:0] second_wait(input logic [1:0] win, input logic sel);
    logic [3:0] w;
    if (sel) begin
      w = 4'd2;
    end else begin
      case (win)
        2'd0:    w = 4'd3;
        2'd1:    w = 4'd5;
        default: w = 4'd9;
      endcase
    end
    return w;
  endfunction

  function automatic bwst_wait_t decode_low(input bwst_wait_t w, input logic [7:0] b);
    bwst_wait_t r;
    r        = w;
    r.sram   = first_wait(b[1:0]);
    r.rom[0] = first_wait(b[3:2]);
    r.rom[1] = second_wait(2'd0, b[4]);
    r.rom[2] = first_wait(b[6:5]);
    r.rom[3] = second_wait(2'd1, b[7]);
    return r;
  endfunction

  function automatic bwst_wait_t decode_high(input bwst_wait_t w, input logic [7:0] b);
    bwst_wait_t r;
    r        = w;
    r.rom[4] = first_wait(b[1:0]);
    r.rom[5] = second_wait(2'd2, b[2]);
    return r;
  endfunction

  logic        is_write;
  logic        is_byte;
  logic        is_half;
  logic        is_word;
  logic [2:0]  bytes;
  logic        low_space;
  logic [3:0]  region;
  logic        io_hit;
  logic        rom_rd;
  logic        seq;
  logic [1:0]  win;
  logic [3:0]  rom_n;
  logic [3:0]  rom_s;
  logic [4:0]  rom_cyc;
  logic [4:0]  cyc;
  logic        wr_lo;
  logic        wr_hi;
  logic        wr_half;
  logic [15:0] half_data;
  logic        hit;
  logic [31:0] rd;
  bwst_wait_t  w;

  assign is_write = (req.op == OP_WRITE);
  assign is_byte  = (req.size == SIZE_BYTE);
  assign is_half  = (req.size == SIZE_HALF);
  assign is_word  = req.size[1];
  assign bytes    = is_byte ? 3'd1 : (is_half ? 3'd2 : 3'd4);

  assign seq_addr_nxt = req.addr + {29'd0, bytes};

  assign low_space = (req.addr[31:28] == 4'h0);
  assign region    = req.addr[27:24];
  assign io_hit    = low_space && (region == REG_IO);
  assign rom_rd    = low_space && !is_write &&
                     (region >= REG_ROM_LO) && (region <= REG_ROM_HI);

  // a rom read at the start of a 128k block is never sequential
  assign seq = (req.addr == seq_addr) && !(rom_rd && (req.addr[16:0] == 17'd0));

  // rom window select, window 3 folds onto window 2
  assign win     = (req.addr[26:25] == 2'd3) ? WIN_LAST : req.addr[26:25];
  assign rom_n   = wait_cur.rom[{win, 1'b0}];
  assign rom_s   = wait_cur.rom[{win, 1'b1}];
  assign rom_cyc = {1'b0, seq ? rom_s : rom_n} + (is_word ? {1'b0, rom_s} : 5'd0);

  // cycle count by region
  always_comb begin
    cyc = 5'd1;
    if (low_space) begin
      case (region) inside
        REG_EWRAM:          cyc = is_word ? 5'd6 : 5'd3;
        REG_PAL, REG_VRAM:  cyc = is_word ? 5'd2 : 5'd1;
        [REG_ROM_LO:REG_ROM_HI]: begin
          if (!is_write) cyc = rom_cyc;
        end
        REG_SRAM: begin
          if (is_byte && (is_write || req.addr <= SRAM_LIMIT)) cyc = {1'b0, wait_cur.sram};
        end
        default:            cyc = 5'd1;
      endcase
    end
  end

  // wait-control lane decode for writes
  always_comb begin
    wr_lo     = 1'b0;
    wr_hi     = 1'b0;
    wr_half   = 1'b0;
    half_data = req.wdata[15:0];
    if (io_hit && is_write) begin
      if (is_byte) begin
        wr_lo = (req.addr == WAIT_CTRL_ADDR);
        wr_hi = (req.addr == WAIT_CTRL_B1);
      end else if (is_half) begin
        wr_half = (req.addr == WAIT_CTRL_ADDR);
      end else begin
        if (req.addr == WAIT_CTRL_ADDR) begin
          wr_half = 1'b1;
        end else if (req.addr == WAIT_CTRL_WLO) begin
          wr_half   = 1'b1;
          half_data = req.wdata[31:16];
        end
      end
    end
  end

  // register update, bit 15 of the raw value is always kept
  always_comb begin
    w = wait_cur;
    if (wr_lo) begin
      w.raw[7:0] = req.wdata[7:0];
      w = decode_low(w, req.wdata[7:0]);
    end
    if (wr_hi) begin
      w.raw[14:8] = req.wdata[6:0];
      w = decode_high(w, req.wdata[7:0]);
    end
    if (wr_half) begin
      w.raw[14:0] = half_data[14:0];
      w = decode_low(w, half_data[7:0]);
      w = decode_high(w, half_data[15:8]);
    end
    wait_nxt = w;
  end

  // wait-control lane reads
  always_comb begin
    hit = 1'b0;
    rd  = 32'd0;
    if (io_hit && !is_write) begin
      if (is_byte) begin
        if (req.addr == WAIT_CTRL_ADDR) begin
          hit = 1'b1;
          rd  = {24'd0, wait_cur.raw[7:0]};
        end else if (req.addr == WAIT_CTRL_B1) begin
          hit = 1'b1;
          rd  = {24'd0, wait_cur.raw[15:8]};
        end
      end else if (is_half) begin
        if (req.addr == WAIT_CTRL_ADDR) begin
          hit = 1'b1;
          rd  = {16'd0, wait_cur.raw};
        end
      end else begin
        if (req.addr == WAIT_CTRL_ADDR) begin
          hit = 1'b1;
          rd  = {16'd0, wait_cur.raw};
        end else if (req.addr == WAIT_CTRL_WLO) begin
          hit = 1'b1;
          rd  = {wait_cur.raw, 16'd0};
        end
      end
    end
  end

  assign rsp.cycles     = cyc;
  assign rsp.sequential = seq;
  assign rsp.reg_hit    = hit;
  assign rsp.rdata      = rd;

endmodule
